[hw/rtl/positional_list_engine_defines.svh]
// ---------------------------------------------------------------------------
// Positional list engine assertion macros
// Concurrent checks, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
`define PLE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PLE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PLE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PLE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hw/rtl/ple_pkg.sv]
// ---------------------------------------------------------------------------
// Positional list engine package
// Sizes, command and status codes, controller states and control structs.
// ---------------------------------------------------------------------------
package ple_pkg;

  localparam int CAPACITY  = 64;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int LEN_W     = 7;
  localparam int VAL_W     = 32;
  localparam int POS_W     = 16;
  localparam int POS_MAG_W = POS_W - 1;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_SEARCH    = 3'd3,
    OP_DEL_FRONT = 3'd4,
    OP_DEL_BACK  = 3'd5,
    OP_DEL_AT    = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SRCH,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic exec;
    logic reduce;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic is_search;
  } stat_t;

endpackage

[hw/rtl/ple_cmd_if.sv]
// ---------------------------------------------------------------------------
// Positional list engine command channel
// Valid/ready channel carrying one list command per beat.
// ---------------------------------------------------------------------------
interface ple_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          op;
  logic signed [ple_pkg::VAL_W-1:0]    value;
  logic signed [ple_pkg::POS_W-1:0]    position;

  modport source (output valid, output op, output value, output position, input ready);
  modport sink   (input valid, input op, input value, input position, output ready);
endinterface

[hw/rtl/ple_res_if.sv]
// ---------------------------------------------------------------------------
// Positional list engine result channel
// Valid/ready channel carrying one command result per beat.
// ---------------------------------------------------------------------------
interface ple_res_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                status;
  logic                      found;
  logic [ple_pkg::LEN_W-1:0] length;

  modport source (output valid, output status, output found, output length, input ready);
  modport sink   (input valid, input status, input found, input length, output ready);
endinterface

[hw/rtl/ple_ctrl.sv]
// ---------------------------------------------------------------------------
// Positional list engine controller
// Sequences accept, execute, search reduction and result emission.
// ---------------------------------------------------------------------------
module ple_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  ple_pkg::stat_t  stat_i,
  output ple_pkg::ctrl_t  ctrl_o
);

  ple_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ple_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ctrl_o      = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      ple_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = ple_pkg::S_EXEC;
        end
      end
      ple_pkg::S_EXEC: begin
        ctrl_o.exec = 1'b1;
        state_d     = stat_i.is_search ? ple_pkg::S_SRCH : ple_pkg::S_EMIT;
      end
      ple_pkg::S_SRCH: begin
        ctrl_o.reduce = 1'b1;
        state_d       = ple_pkg::S_EMIT;
      end
      ple_pkg::S_EMIT: begin
        if (out_free) begin
          ctrl_o.emit = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ple_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ple_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/ple_datapath.sv]
// ---------------------------------------------------------------------------
// Positional list engine datapath
// Shifting cell array with per-cell compare, length counter and result registers.
// ---------------------------------------------------------------------------
module ple_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ple_pkg::ctrl_t                   ctrl_i,
  output ple_pkg::stat_t                   stat_o,
  input  logic [2:0]                       op_i,
  input  logic signed [ple_pkg::VAL_W-1:0] value_i,
  input  logic signed [ple_pkg::POS_W-1:0] position_i,
  output logic [1:0]                       status_o,
  output logic                             found_o,
  output logic [ple_pkg::LEN_W-1:0]        length_o
);

  ple_pkg::op_e                    op_q;
  logic [ple_pkg::VAL_W-1:0]       val_q;
  logic [ple_pkg::POS_W-1:0]       pos_q;
  logic [ple_pkg::LEN_W-1:0]       len_q, len_d;
  logic [ple_pkg::VAL_W-1:0]       cell_q [ple_pkg::CAPACITY];
  logic [ple_pkg::CAPACITY-1:0]    match_q;
  ple_pkg::status_e                res_status_q, res_status_d;
  logic                            res_found_q;
  logic [1:0]                      out_status_q;
  logic                            out_found_q;
  logic [ple_pkg::LEN_W-1:0]       out_length_q;

  logic                            pos_neg, pos_in, full, empty, do_ins, do_del;
  logic [ple_pkg::POS_MAG_W-1:0]   pos_mag;
  logic [ple_pkg::LEN_W-1:0]       len_m1;
  logic [ple_pkg::IDX_W-1:0]       ins_idx, del_idx;

  // latch command
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      op_q  <= ple_pkg::op_e'(op_i);
      val_q <= value_i;
      pos_q <= position_i;
    end
  end

  assign stat_o.is_search = (op_q == ple_pkg::OP_SEARCH);

  assign pos_neg = pos_q[ple_pkg::POS_W-1];
  assign pos_mag = pos_q[ple_pkg::POS_MAG_W-1:0];
  assign pos_in  = pos_mag < ple_pkg::POS_MAG_W'(len_q);
  assign full    = (len_q >= ple_pkg::LEN_W'(ple_pkg::CAPACITY));
  assign empty   = (len_q == '0);
  assign len_m1  = len_q - ple_pkg::LEN_W'(1);

  always_comb begin
    do_ins       = 1'b0;
    do_del       = 1'b0;
    res_status_d = ple_pkg::ST_OK;
    ins_idx      = '0;
    del_idx      = '0;
    len_d        = len_q;
    case (op_q)
      ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_BACK, ple_pkg::OP_INS_AT: begin
        if (op_q == ple_pkg::OP_INS_AT && pos_neg) begin
          res_status_d = ple_pkg::ST_INVALID;
        end else if (full) begin
          res_status_d = ple_pkg::ST_FULL;
        end else begin
          do_ins = 1'b1;
          len_d  = len_q + ple_pkg::LEN_W'(1);
        end
        if (op_q == ple_pkg::OP_INS_BACK) begin
          ins_idx = len_q[ple_pkg::IDX_W-1:0];
        end else if (op_q == ple_pkg::OP_INS_AT) begin
          ins_idx = pos_in ? pos_mag[ple_pkg::IDX_W-1:0] : len_q[ple_pkg::IDX_W-1:0];
        end
      end
      ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_BACK, ple_pkg::OP_DEL_AT: begin
        if (op_q == ple_pkg::OP_DEL_AT && pos_neg) begin
          res_status_d = ple_pkg::ST_INVALID;
        end else if (empty) begin
          res_status_d = ple_pkg::ST_EMPTY;
        end else begin
          do_del = 1'b1;
          len_d  = len_m1;
        end
        if (op_q == ple_pkg::OP_DEL_BACK) begin
          del_idx = len_m1[ple_pkg::IDX_W-1:0];
        end else if (op_q == ple_pkg::OP_DEL_AT) begin
          del_idx = pos_in ? pos_mag[ple_pkg::IDX_W-1:0] : len_m1[ple_pkg::IDX_W-1:0];
        end
      end
      default: begin
        res_status_d = ple_pkg::ST_OK;
      end
    endcase
  end

  // cell array: shift right on insert, left on delete, compare on search
  for (genvar i = 0; i < ple_pkg::CAPACITY; i++) begin : g_cell
    localparam logic [ple_pkg::IDX_W-1:0] MyIdx = ple_pkg::IDX_W'(i);
    logic ins_here;

    assign ins_here = do_ins && (MyIdx == ins_idx);

    if (i == 0) begin : g_first
      logic del_shift;

      assign del_shift = do_del && (MyIdx >= del_idx);

      always_ff @(posedge clk_i) begin
        if (ctrl_i.exec) begin
          if (ins_here) begin
            cell_q[i] <= val_q;
          end else if (del_shift) begin
            cell_q[i] <= cell_q[i+1];
          end
        end
      end
    end else if (i == ple_pkg::CAPACITY - 1) begin : g_last
      logic ins_shift;

      assign ins_shift = do_ins && (MyIdx > ins_idx);

      always_ff @(posedge clk_i) begin
        if (ctrl_i.exec) begin
          if (ins_here) begin
            cell_q[i] <= val_q;
          end else if (ins_shift) begin
            cell_q[i] <= cell_q[i-1];
          end
        end
      end
    end else begin : g_mid
      logic ins_shift, del_shift;

      assign ins_shift = do_ins && (MyIdx > ins_idx);
      assign del_shift = do_del && (MyIdx >= del_idx);

      always_ff @(posedge clk_i) begin
        if (ctrl_i.exec) begin
          if (ins_here) begin
            cell_q[i] <= val_q;
          end else if (ins_shift) begin
            cell_q[i] <= cell_q[i-1];
          end else if (del_shift) begin
            cell_q[i] <= cell_q[i+1];
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (ctrl_i.exec) begin
        match_q[i] <= (cell_q[i] == val_q) && (ple_pkg::LEN_W'(i) < len_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (ctrl_i.exec) begin
      len_q <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      res_status_q <= res_status_d;
      res_found_q  <= 1'b0;
    end else if (ctrl_i.reduce) begin
      res_found_q  <= |match_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_length_q <= len_q;
    end
  end

  assign status_o = out_status_q;
  assign found_o  = out_found_q;
  assign length_o = out_length_q;

endmodule

[hw/rtl/positional_list_engine.sv]
// A command steps through the accept, execute and emit states, a search also through
//   a reduction state; emit waits until the output register is free, and the result
//   beat is then registered. No new command is taken before the previous one is emitted.
// A new command is taken while the previous result waits in the output register.
// Reset clears the length and the control state; list contents stay undefined.
// ---------------------------------------------------------------------------
// Positional list engine
// Bounded ordered list with positional insert, delete and key search.
// ---------------------------------------------------------------------------
`include "positional_list_engine_defines.svh"

module positional_list_engine (
  input  logic clk_i,
  input  logic rst_ni,
  ple_cmd_if.sink   cmd_i,
  ple_res_if.source res_o
);

  ple_pkg::ctrl_t ctrl;
  ple_pkg::stat_t stat;

  ple_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (cmd_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  ple_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .stat_o     (stat),
    .op_i       (cmd_i.op),
    .value_i    (cmd_i.value),
    .position_i (cmd_i.position),
    .status_o   (res_o.status),
    .found_o    (res_o.found),
    .length_o   (res_o.length)
  );

  `PLE_ASSERT_NXT(a_accept_exec, clk_i, rst_ni, cmd_i.valid && cmd_i.ready, ctrl.exec)
  `PLE_ASSERT_NXT(a_emit_valid, clk_i, rst_ni, ctrl.emit, res_o.valid)
  `PLE_ASSERT_IMP(a_len_bound, clk_i, rst_ni, res_o.valid, res_o.length <= ple_pkg::LEN_W'(ple_pkg::CAPACITY))
  `PLE_ASSERT_IMP(a_found_ok, clk_i, rst_ni, res_o.valid && res_o.found, res_o.status == ple_pkg::ST_OK)

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Positional list engine testbench
// Drives list commands over the command channel with random gaps and
// back-pressure, mirrors the list in a queue, and checks every result beat
// against the mirrored status, found flag and length.
// ---------------------------------------------------------------------------
module tb_top;

  localparam logic [2:0] OpUnused      = 3'd7;
  localparam int         WatchdogLimit = 1000;
  localparam int         DrainCycles   = 8;

  typedef struct packed {
    ple_pkg::status_e            status;
    logic                        found;
    logic [ple_pkg::LEN_W-1:0]   length;
  } list_result_t;

  logic clk;
  logic rst_n;

  ple_cmd_if cmd_if ();
  ple_res_if res_if ();

  positional_list_engine i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  logic signed [ple_pkg::VAL_W-1:0] list_model[$];
  list_result_t                     pending_results[$];
  int                               fail_count;
  int                               src_idle_pct;
  int                               snk_idle_pct;
  int                               idle_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic list_result_t apply_list_cmd(
    input logic [2:0] op,
    input logic signed [ple_pkg::VAL_W-1:0] value,
    input logic [ple_pkg::POS_W-1:0] position);
    list_result_t r;
    logic         neg;
    int unsigned  mag;
    int unsigned  len;
    int unsigned  idx;
    neg      = position[ple_pkg::POS_W-1];
    mag      = 32'(position[ple_pkg::POS_MAG_W-1:0]);
    len      = list_model.size();
    r.status = ple_pkg::ST_OK;
    r.found  = 1'b0;
    case (op)
      ple_pkg::OP_INS_FRONT, ple_pkg::OP_INS_BACK, ple_pkg::OP_INS_AT: begin
        if (op == ple_pkg::OP_INS_AT && neg) begin
          r.status = ple_pkg::ST_INVALID;
        end else if (len >= ple_pkg::CAPACITY) begin
          r.status = ple_pkg::ST_FULL;
        end else begin
          if (op == ple_pkg::OP_INS_FRONT) idx = 0;
          else if (op == ple_pkg::OP_INS_BACK) idx = len;
          else idx = (mag < len) ? mag : len;
          list_model.insert(idx, value);
        end
      end
      ple_pkg::OP_SEARCH: begin
        foreach (list_model[i]) begin
          if (list_model[i] == value) r.found = 1'b1;
        end
      end
      ple_pkg::OP_DEL_FRONT, ple_pkg::OP_DEL_BACK, ple_pkg::OP_DEL_AT: begin
        if (op == ple_pkg::OP_DEL_AT && neg) begin
          r.status = ple_pkg::ST_INVALID;
        end else if (len == 0) begin
          r.status = ple_pkg::ST_EMPTY;
        end else begin
          if (op == ple_pkg::OP_DEL_FRONT) idx = 0;
          else if (op == ple_pkg::OP_DEL_BACK) idx = len - 1;
          else idx = (mag < len) ? mag : len - 1;
          list_model.delete(idx);
        end
      end
      default: begin
      end
    endcase
    r.length = ple_pkg::LEN_W'(list_model.size());
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  task automatic send_cmd(input logic [2:0] op,
                          input logic signed [ple_pkg::VAL_W-1:0] value,
                          input logic [ple_pkg::POS_W-1:0] position);
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid    <= 1'b1;
    cmd_if.op       <= op;
    cmd_if.value    <= value;
    cmd_if.position <= position;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    pending_results.push_back(apply_list_cmd(op, value, position));
  endtask

  task automatic test_empty_list();
    send_cmd(ple_pkg::OP_DEL_FRONT, 0, 16'd0);
    send_cmd(ple_pkg::OP_DEL_BACK, 0, 16'd0);
    send_cmd(ple_pkg::OP_DEL_AT, 0, 16'd0);
    send_cmd(ple_pkg::OP_DEL_AT, 0, 16'hFFFF);
    send_cmd(ple_pkg::OP_SEARCH, 0, 16'd0);
    send_cmd(OpUnused, 32'hFFFF_FFFF, 16'hFFFF);
  endtask

  task automatic test_extremes_and_clamp();
    send_cmd(ple_pkg::OP_INS_AT, 1, 16'h8000);
    send_cmd(ple_pkg::OP_INS_FRONT, 32'h8000_0000, 16'd0);
    send_cmd(ple_pkg::OP_INS_BACK, 32'h7FFF_FFFF, 16'd0);
    send_cmd(ple_pkg::OP_INS_AT, 0, 16'h7FFF);
    send_cmd(ple_pkg::OP_INS_AT, -1, 16'd0);
    send_cmd(ple_pkg::OP_INS_AT, 5, 16'd1);
    send_cmd(ple_pkg::OP_SEARCH, 32'h8000_0000, 16'd0);
    send_cmd(ple_pkg::OP_SEARCH, 32'h7FFF_FFFF, 16'd0);
    send_cmd(ple_pkg::OP_SEARCH, 12345, 16'd0);
    send_cmd(ple_pkg::OP_DEL_AT, 0, 16'h7FFF);
    send_cmd(ple_pkg::OP_DEL_AT, 0, 16'd1);
    send_cmd(OpUnused, 0, 16'd0);
    send_cmd(ple_pkg::OP_DEL_AT, 0, 16'h8000);
    send_cmd(ple_pkg::OP_DEL_BACK, 0, 16'd0);
    send_cmd(ple_pkg::OP_DEL_FRONT, 0, 16'd0);
    send_cmd(ple_pkg::OP_DEL_BACK, 0, 16'd0);
  endtask

  // ins_pct biases the share of inserts among inserts and deletes
  task automatic run_random_traffic(input int count, input int ins_pct);
    logic [2:0]                       op;
    logic signed [ple_pkg::VAL_W-1:0] value;
    logic [ple_pkg::POS_W-1:0]        position;
    int                               r;
    int                               len;
    for (int n = 0; n < count; n++) begin
      r   = $urandom_range(99);
      len = list_model.size();
      if ($urandom_range(1)) value = $urandom_range(0, 31) - 16;
      else value = $urandom;
      case ($urandom_range(9))
        0:       position = {1'b1, 15'($urandom)};
        1:       position = {1'b0, 15'($urandom)};
        2:       position = ple_pkg::POS_W'(len);
        default: position = ple_pkg::POS_W'($urandom_range(0, len));
      endcase
      if (r < 3) begin
        op       = 3'($urandom_range(7));
        value    = $urandom;
        position = 16'($urandom);
      end else if (r < 18) begin
        op = ple_pkg::OP_SEARCH;
        if (len > 0 && $urandom_range(1)) value = list_model[$urandom_range(0, len - 1)];
      end else if (r < 18 + (82 * ins_pct) / 100) begin
        case ($urandom_range(3))
          0:       op = ple_pkg::OP_INS_FRONT;
          1:       op = ple_pkg::OP_INS_BACK;
          default: op = ple_pkg::OP_INS_AT;
        endcase
      end else begin
        case ($urandom_range(3))
          0:       op = ple_pkg::OP_DEL_FRONT;
          1:       op = ple_pkg::OP_DEL_BACK;
          default: op = ple_pkg::OP_DEL_AT;
        endcase
      end
      send_cmd(op, value, position);
    end
  endtask

  task automatic test_fill_and_drain();
    run_random_traffic(110, 85);
    run_random_traffic(110, 15);
  endtask

  task automatic test_random_mix();
    run_random_traffic(110, 50);
  endtask

  always @(posedge clk) begin
    res_if.ready <= rst_n && ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat", int'(res_if.length), 0);
      end else begin
        want = pending_results.pop_front();
        if (res_if.status !== want.status)
          report_mismatch("status", int'(res_if.status), int'(want.status));
        if (res_if.found !== want.found)
          report_mismatch("found", int'(res_if.found), int'(want.found));
        if (res_if.length !== want.length)
          report_mismatch("length", int'(res_if.length), int'(want.length));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WatchdogLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n           = 1'b0;
    cmd_if.valid    = 1'b0;
    cmd_if.op       = '0;
    cmd_if.value    = '0;
    cmd_if.position = '0;
    res_if.ready    = 1'b0;
    fail_count      = 0;
    idle_cycles     = 0;
    src_idle_pct    = 15;
    snk_idle_pct    = 54;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_extremes_and_clamp();
    test_fill_and_drain();
    test_random_mix();

    src_idle_pct = 54;
    snk_idle_pct = 15;
    test_fill_and_drain();
    test_random_mix();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_fill_and_drain();
    test_random_mix();

    cmd_if.valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
